[hdl/elite_partial_selection_sort_defines.svh]
// Assertion macros shared by the checker of the elite selector.
// No dependencies; the user supplies clk and arst_n in scope.
`ifndef ELITE_PARTIAL_SELECTION_SORT_DEFINES_SVH
`define ELITE_PARTIAL_SELECTION_SORT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define EPSS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define EPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/epss_pkg.sv]
// Package of the elite selector: sizes, payload structs and register map.
// No dependencies.
`timescale 1ns / 1ps

package epss_pkg;

	// population storage
	localparam int POP_MAX     = 64;
	localparam int MAX_RESULTS = 64;
	localparam int AW          = $clog2(POP_MAX);
	localparam int CW          = $clog2(POP_MAX + 1);
	localparam int SEL_W       = (CW > 8) ? CW : 8;

	// field widths
	localparam int FIT_W = 32;
	localparam int IDX_W = 6;
	localparam int EC_W  = 7;

	// register map (word index from paddr[2])
	localparam logic REG_ELITE_COUNT = 1'b0;
	localparam logic [EC_W-1:0] ELITE_COUNT_RESET = 7'd2;

	typedef struct packed {
		logic signed [FIT_W-1:0] fitness;
		logic                    load_last;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        elite_index;
		logic signed [FIT_W-1:0] elite_fitness;
		logic                    elite_last;
	} out_t;

	// one stored individual
	typedef struct packed {
		logic signed [FIT_W-1:0] fit;
		logic [IDX_W-1:0]        idx;
	} entry_t;

endpackage

[hdl/elite_partial_selection_sort.sv]
// Top level of the elite selector: APB register block and selection engine.
// Depends on epss_pkg, epss_regs and epss_core.
//
// Usage:
//   Load a population one individual per transaction: present item and raise
//   start; the transaction is taken at an edge where start is high and busy low.
//   While busy is low, a population streams in at one item per cycle.
//   The item with load_last set closes the population; items beyond POP_MAX
//   are dropped. The elite count (elite_count rounded up to even, clamped to
//   the population size) is then picked by a selection sort that reuses one
//   comparator and the population store (one write and one read port).
//   While selecting, busy is high. With an elite count of zero the block
//   never goes busy, and the population yields no result.
//   One result per pass appears on result for a single cycle, flagged by
//   result_valid, in ascending fitness order; elite_last marks the final one.
//   The receiver cannot stall: every result must be taken when shown.
//   elite_count is written over APB at byte address 0; the user must do so only
//   while idle, as the block does not enforce it. Reset clears the load count
//   and returns elite_count to 2; stored fitness values are left as they were.
`timescale 1ns / 1ps

module elite_partial_selection_sort import epss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  in_t         item,
	output out_t        result,
	output logic        result_valid
);

	logic [EC_W-1:0] elite_count;

	epss_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.elite_count (elite_count)
	);

	epss_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.elite_count  (elite_count),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

[hdl/epss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module epss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/epss_regs.sv]
// APB register block of the elite selector: holds elite_count.
// Depends on epss_pkg.
`timescale 1ns / 1ps

module epss_regs import epss_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output logic [EC_W-1:0] elite_count
);

	logic [EC_W-1:0] elite_count_q;
	logic            wr_en;

	assign pready      = 1'b1;
	assign wr_en       = psel && penable && pwrite && pready;
	assign elite_count = elite_count_q;

	// register write, access phase only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elite_count_q <= ELITE_COUNT_RESET;
		end else if (wr_en && (paddr[2] == REG_ELITE_COUNT)) begin
			elite_count_q <= pwdata[EC_W-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ELITE_COUNT) begin
			prdata = {{(32 - EC_W){1'b0}}, elite_count_q};
		end
	end

endmodule

[hdl/epss_core.sv]
// Load and selection engine: population store, shared comparator and sequencer.
// Depends on epss_pkg and epss_ram.
`timescale 1ns / 1ps

module epss_core import epss_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  in_t             item,
	input  logic [EC_W-1:0] elite_count,
	output out_t            result,
	output logic            result_valid
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_SCAN,
		S_PUT_BEST,
		S_PUT_HEAD
	} state_t;

	localparam int EW = $bits(entry_t);

	state_t        state_q;
	logic          busy_q;
	logic          result_valid_q;
	out_t          result_q;
	logic [CW-1:0] lc_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] p_q;
	logic [CW-1:0] q_q;
	logic          vld_s1;
	logic          head_s1;
	logic [AW-1:0] addr_s1;

	entry_t        best_q;
	entry_t        head_q;
	logic [AW-1:0] best_addr_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] n_acc;
	logic [SEL_W-1:0] ec_even;
	logic [SEL_W-1:0] cnt_tmp;
	logic [CW-1:0] cnt_acc;
	logic          pass_last;
	logic          is_less;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd;

	assign busy         = busy_q;
	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign rd           = entry_t'(ram_rdata);

	// transaction accept and elite count for this population
	always_comb begin
		accept  = start && !busy_q;
		full    = (lc_q == CW'(POP_MAX));
		n_acc   = full ? lc_q : lc_q + CW'(1);
		ec_even = SEL_W'(elite_count) + SEL_W'(elite_count[0]);
		cnt_tmp = ec_even;
		if (cnt_tmp > SEL_W'(n_acc)) begin
			cnt_tmp = SEL_W'(n_acc);
		end
		if (cnt_tmp > SEL_W'(MAX_RESULTS)) begin
			cnt_tmp = SEL_W'(MAX_RESULTS);
		end
		cnt_acc   = CW'(cnt_tmp);
		pass_last = ((CW'(p_q) + CW'(1)) == cnt_q);
	end

	// shared comparator: signed fitness against the current best
	assign is_less = (rd.fit < best_q.fit);

	// store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lc_q[AW-1:0];
		ram_wdata = '{fit: item.fitness, idx: IDX_W'(lc_q)};
		ram_raddr = q_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ram_we = accept && !full;
			end
			S_HEAD: begin
				ram_raddr = p_q;
			end
			S_PUT_BEST: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = best_q;
			end
			S_PUT_HEAD: begin
				ram_we    = 1'b1;
				ram_waddr = best_addr_q;
				ram_wdata = head_q;
			end
			default: begin
			end
		endcase
	end

	epss_ram #(
		.WIDTH(EW),
		.DEPTH(POP_MAX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: load, then one scan-and-swap pass per elite position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			lc_q           <= '0;
			n_q            <= '0;
			cnt_q          <= '0;
			p_q            <= '0;
			q_q            <= '0;
			vld_s1         <= 1'b0;
			head_s1        <= 1'b0;
			addr_s1        <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.load_last) begin
							lc_q  <= '0;
							n_q   <= n_acc;
							cnt_q <= cnt_acc;
							p_q   <= '0;
							if (cnt_acc != '0) begin
								state_q <= S_HEAD;
								busy_q  <= 1'b1;
							end
						end else if (!full) begin
							lc_q <= lc_q + CW'(1);
						end
					end
				end
				S_HEAD: begin
					vld_s1  <= 1'b1;
					head_s1 <= 1'b1;
					addr_s1 <= p_q;
					q_q     <= CW'(p_q) + CW'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (q_q < n_q) begin
						vld_s1  <= 1'b1;
						head_s1 <= 1'b0;
						addr_s1 <= q_q[AW-1:0];
						q_q     <= q_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= S_PUT_BEST;
						end
					end
				end
				S_PUT_BEST: begin
					result_valid_q         <= 1'b1;
					result_q.elite_index   <= best_q.idx;
					result_q.elite_fitness <= best_q.fit;
					result_q.elite_last    <= pass_last;
					state_q                <= S_PUT_HEAD;
				end
				S_PUT_HEAD: begin
					if (pass_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						p_q     <= p_q + AW'(1);
						state_q <= S_HEAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// running minimum: first strictly smaller entry wins
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && vld_s1) begin
			if (head_s1) begin
				best_q      <= rd;
				head_q      <= rd;
				best_addr_q <= addr_s1;
			end else if (is_less) begin
				best_q      <= rd;
				best_addr_q <= addr_s1;
			end
		end
	end

endmodule

[hdl/epss_chk.sv]
// Port-level checker for the elite selector, bound to the top level.
// Depends on epss_pkg and elite_partial_selection_sort_defines.svh.
`timescale 1ns / 1ps
`include "elite_partial_selection_sort_defines.svh"

module epss_chk import epss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_t  item,
	input out_t result,
	input logic result_valid
);

	// results only come out during selection
	`EPSS_ASSERT_SAME(a_result_in_busy, result_valid, busy, "result outside selection")

	// a result strobe is never directly followed by another
	`EPSS_ASSERT_NEXT(a_result_gap, result_valid, !result_valid, "back-to-back results")

	// a plain load never starts a selection
	`EPSS_ASSERT_NEXT(a_load_idle, start && !busy && !item.load_last, !busy,
		"busy after a non-final load")

	// the final elite ends the selection
	`EPSS_ASSERT_NEXT(a_last_ends, result_valid && result.elite_last, !busy,
		"still busy after final elite")

endmodule

bind elite_partial_selection_sort epss_chk u_chk (.*);

[bench/tb_top.sv]
// Self-checking bench for the elite selector: loads populations over the command port,
// predicts the sorted elite in the bench and checks every result strobe.
// Depends on epss_pkg and elite_partial_selection_sort.
`timescale 1ns / 1ps

module tb_top;
	import epss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 320;
	localparam int SETTLE      = 8;

	localparam logic signed [FIT_W-1:0] FIT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [FIT_W-1:0] FIT_MIN = 32'sh8000_0000;

	// byte addresses: word index sits in paddr[2]
	localparam logic [2:0] ADDR_ELITE_COUNT = {REG_ELITE_COUNT, 2'b00};
	localparam logic [2:0] ADDR_SPARE       = {~REG_ELITE_COUNT, 2'b00};

	// sender idle percentage per random phase
	localparam int PHASES = 3;
	localparam int PHASE_IDLE [PHASES] = '{0, 67, 31};

	typedef enum logic {ROW_LOAD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [2:0]       addr;
		logic [EC_W-1:0]  cfg;
		in_t              it;
		bit               typed;
		out_t             res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	in_t         item;
	out_t        result;
	logic        result_valid;

	// bench copy of the block state
	logic signed [FIT_W-1:0] pop_fit [POP_MAX];
	logic [IDX_W-1:0]        pop_pos [POP_MAX];
	int                      pop_size;
	logic [EC_W-1:0]         elite_req;

	out_t elite_due [$];
	out_t due_head;
	row_t plan [$];
	int   errors;
	int   cycle_count;
	int   idle_pct;

	elite_partial_selection_sort u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_valid (result_valid)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic void note_error(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		$display("%0t %s: expected %0h actual %0h", $time, what, want, got);
	endfunction

	// store one individual; on the last one pick the elite by selection sort
	task automatic store_individual(input in_t it, input bit typed, input out_t typed_res);
		int                      cnt;
		int                      best;
		logic signed [FIT_W-1:0] tf;
		logic [IDX_W-1:0]        ti;
		if (pop_size < POP_MAX) begin
			pop_fit[pop_size] = it.fitness;
			pop_pos[pop_size] = IDX_W'(pop_size);
			pop_size++;
		end
		if (it.load_last) begin
			cnt = int'(elite_req) + int'(elite_req[0]);
			if (cnt > pop_size)
				cnt = pop_size;
			if (cnt > MAX_RESULTS)
				cnt = MAX_RESULTS;
			for (int p = 0; p < cnt; p++) begin
				best = p;
				// first strictly smaller wins, so ties keep the earlier entry
				for (int q = p + 1; q < pop_size; q++)
					if (pop_fit[q] < pop_fit[best])
						best = q;
				tf = pop_fit[p];
				ti = pop_pos[p];
				pop_fit[p] = pop_fit[best];
				pop_pos[p] = pop_pos[best];
				pop_fit[best] = tf;
				pop_pos[best] = ti;
			end
			if (typed)
				elite_due.push_back(typed_res);
			else
				for (int p = 0; p < cnt; p++)
					elite_due.push_back('{elite_index: pop_pos[p], elite_fitness: pop_fit[p],
						elite_last: (p == cnt - 1)});
			pop_size = 0;
		end
	endtask

	// present one item and hold it until the block takes the transaction
	task automatic send_load(input in_t it, input bit typed, input out_t typed_res);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		store_individual(it, typed, typed_res);
	endtask

	// drop start and let every pending result come out
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (elite_due.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [EC_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_ELITE_COUNT)
			elite_req = val;
	endtask

	// read back elite_count and compare with the bench copy
	task automatic check_elite_count();
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_ELITE_COUNT;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[EC_W-1:0] !== elite_req)
			note_error("elite_count readback", 64'(elite_req), 64'(rd[EC_W-1:0]));
	endtask

	function automatic row_t pop_row(logic signed [FIT_W-1:0] f, logic last);
		row_t r;
		r.kind  = ROW_LOAD;
		r.addr  = ADDR_ELITE_COUNT;
		r.cfg   = '0;
		r.it    = '{fitness: f, load_last: last};
		r.typed = 1'b0;
		r.res   = '0;
		return r;
	endfunction

	// population of one: the single result is the item itself
	function automatic row_t solo_row(logic signed [FIT_W-1:0] f);
		row_t r;
		r       = pop_row(f, 1'b1);
		r.typed = 1'b1;
		r.res   = '{elite_index: '0, elite_fitness: f, elite_last: 1'b1};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [2:0] addr, logic [EC_W-1:0] val);
		row_t r;
		r      = pop_row('0, 1'b0);
		r.kind = ROW_CFG;
		r.addr = addr;
		r.cfg  = val;
		return r;
	endfunction

	// result check: one strobe, one transaction, compared with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (elite_due.size() == 0) begin
				note_error("unexpected result", 64'(0), 64'(result));
			end else begin
				due_head = elite_due.pop_front();
				if (result.elite_index !== due_head.elite_index)
					note_error("elite_index", 64'(due_head.elite_index), 64'(result.elite_index));
				if (result.elite_fitness !== due_head.elite_fitness)
					note_error("elite_fitness", 64'(due_head.elite_fitness),
						64'(result.elite_fitness));
				if (result.elite_last !== due_head.elite_last)
					note_error("elite_last", 64'(due_head.elite_last), 64'(result.elite_last));
			end
		end
	end

	initial begin
		int                      loaded;
		int                      size;
		int                      style;
		int                      pick;
		logic [EC_W-1:0]         req;
		logic signed [FIT_W-1:0] f;
		in_t                     it;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start       = 1'b0;
		item        = '0;
		errors      = 0;
		cycle_count = 0;
		idle_pct    = 0;
		pop_size    = 0;
		elite_req   = ELITE_COUNT_RESET;

		// directed plan: extremes, ties, zero elite, odd count, clamping, spare address
		plan.push_back(solo_row(FIT_MAX));
		plan.push_back(solo_row(FIT_MIN));
		plan.push_back(pop_row(32'sd5, 1'b0));
		plan.push_back(pop_row(-32'sd3, 1'b0));
		plan.push_back(pop_row(-32'sd3, 1'b0));
		plan.push_back(pop_row(32'sd0, 1'b1));
		plan.push_back(cfg_row(ADDR_ELITE_COUNT, 7'd0));
		plan.push_back(pop_row(32'sd1, 1'b0));
		plan.push_back(pop_row(32'sd2, 1'b1));
		plan.push_back(cfg_row(ADDR_ELITE_COUNT, 7'd3));
		plan.push_back(pop_row(32'sd10, 1'b0));
		plan.push_back(pop_row(FIT_MIN, 1'b0));
		plan.push_back(pop_row(FIT_MAX, 1'b0));
		plan.push_back(pop_row(-32'sd1, 1'b0));
		plan.push_back(pop_row(32'sd7, 1'b1));
		plan.push_back(cfg_row(ADDR_ELITE_COUNT, 7'd1));
		plan.push_back(solo_row(32'sd42));
		plan.push_back(cfg_row(ADDR_SPARE, 7'd0));
		plan.push_back(pop_row(32'sd9, 1'b0));
		plan.push_back(pop_row(32'sd8, 1'b1));
		plan.push_back(cfg_row(ADDR_ELITE_COUNT, 7'd64));
		plan.push_back(pop_row(32'sd0, 1'b0));
		plan.push_back(pop_row(32'sd0, 1'b0));
		plan.push_back(pop_row(-32'sd1, 1'b1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_elite_count();
		foreach (plan[r]) begin
			case (plan[r].kind)
				ROW_CFG: begin
					wait_idle();
					apb_write(plan[r].addr, plan[r].cfg);
					check_elite_count();
				end
				default: send_load(plan[r].it, plan[r].typed, plan[r].res);
			endcase
		end

		// random populations, one idling mode per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = PHASE_IDLE[ph];
			loaded   = 0;
			while (loaded < RAND_ITEMS / PHASES) begin
				if ($urandom_range(2) == 0) begin
					pick = $urandom_range(9);
					case (pick)
						0:       req = 7'd0;
						1:       req = 7'd64;
						2:       req = 7'd1;
						default: req = EC_W'($urandom_range(64));
					endcase
					wait_idle();
					apb_write(ADDR_ELITE_COUNT, req);
					check_elite_count();
				end
				// mostly small populations; a few full or overflowing ones
				pick = $urandom_range(99);
				if (pick < 75)
					size = $urandom_range(12, 1);
				else if (pick < 88)
					size = $urandom_range(63, 13);
				else if (pick < 95)
					size = POP_MAX;
				else
					size = $urandom_range(POP_MAX + 6, POP_MAX + 1);
				style = $urandom_range(2);
				for (int i = 0; i < size; i++) begin
					case (style)
						0: f = $urandom;
						1: f = $signed($urandom_range(7)) - 4;    // many ties
						default: begin
							case ($urandom_range(4))
								0:       f = FIT_MIN;
								1:       f = FIT_MAX;
								2:       f = '0;
								3:       f = -32'sd1;
								default: f = $urandom;
							endcase
						end
					endcase
					it = '{fitness: f, load_last: (i == size - 1)};
					send_load(it, 1'b0, '0);
					loaded++;
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
